@@ hdl/ott_pkg.sv @@
// ----------------------------------------------------------------------------
// ott_pkg
// Shared widths, constants, types and the trim delta table of the oscillator
// temperature trim unit.
// ----------------------------------------------------------------------------
package ott_pkg;

  // sensor resolution; sample and calibration code keep this many low bits
  localparam int SENSOR_BITS   = 12;
  // number of usable entries of the trim table (index = temperature + TEMP_BASE)
  localparam int TABLE_ENTRIES = 125;

  // fixed field widths of the ports
  localparam int SAMPLE_W   = 12;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int BYTE_W     = 8;

  localparam int TEMP_BASE      = 40;
  localparam int ROM_SIZE       = 125;
  localparam int CAL_TEMP_RESET = 25;

  // round(10*d/63) = floor((10*|d| + 31) / 63); the divide by 63 is a multiply
  // by ceil(2^RECIP_SHIFT / 63), exact for every operand below 2^RECIP_SHIFT/59
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] RECIP = 21'd1065221;
  localparam int ROUND_BIAS  = 31;

  localparam int MAG_W  = SENSOR_BITS + 4;      // 10*|d| + 31
  localparam int PROD_W = MAG_W + RECIP_W;
  localparam int QUOT_W = SENSOR_BITS - 1;      // quotient < 2^(SENSOR_BITS-2)
  localparam int TEMP_W = SENSOR_BITS + 2;      // cal temperature +/- quotient
  localparam int IDX_W  = 10;                   // signed index before clamping
  localparam int DELTA_W = 5;
  localparam int SUM_W  = 10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CAL_TEMPERATURE = 2'd0,
    CFG_CAL_SENSOR_CODE = 2'd1,
    CFG_DEFAULT_TRIM    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] prod;
  } scale_t;

  typedef struct packed {
    logic [BYTE_W-1:0]        trim;
    logic signed [BYTE_W-1:0] temp;
    logic                     idx_clamp;
    logic                     trim_clamp;
  } result_t;

  // trim delta per degree from -40 upward; past the stored entries reads -1
  function automatic logic signed [DELTA_W-1:0] trim_delta(input logic [BYTE_W-1:0] idx);
    logic signed [DELTA_W-1:0] d;
    if (idx < 8'd2) begin
      d = 5'sd8;
    end else if (idx < 8'd10) begin
      d = 5'sd7;
    end else if (idx < 8'd18) begin
      d = 5'sd6;
    end else if (idx < 8'd26) begin
      d = 5'sd5;
    end else if (idx < 8'd33) begin
      d = 5'sd4;
    end else if (idx < 8'd41) begin
      d = 5'sd3;
    end else if (idx < 8'd50) begin
      d = 5'sd2;
    end else if (idx < 8'd60) begin
      d = 5'sd1;
    end else if (idx < 8'd77) begin
      d = 5'sd0;
    end else begin
      d = -5'sd1;
    end
    return d;
  endfunction

endpackage

@@ hdl/ott_scale.sv @@
// ----------------------------------------------------------------------------
// ott_scale
// Sensor code difference, times ten plus rounding bias, times the reciprocal
// of 63. The quotient sits at bit RECIP_SHIFT of the product.
// ----------------------------------------------------------------------------
module ott_scale (
  input  logic [ott_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [ott_pkg::SAMPLE_W-1:0] cal_code_i,
  output ott_pkg::scale_t              scale_o
);

  logic [ott_pkg::SENSOR_BITS-1:0] sample;
  logic [ott_pkg::SENSOR_BITS-1:0] code;
  logic signed [ott_pkg::SENSOR_BITS:0] diff;
  logic signed [ott_pkg::SENSOR_BITS:0] diff_abs;
  logic [ott_pkg::SENSOR_BITS-1:0] mag;
  logic [ott_pkg::MAG_W-1:0] biased;

  assign sample   = ott_pkg::SENSOR_BITS'(sample_i);
  assign code     = ott_pkg::SENSOR_BITS'(cal_code_i);
  assign diff     = $signed({1'b0, code}) - $signed({1'b0, sample});
  assign diff_abs = diff[ott_pkg::SENSOR_BITS] ? -diff : diff;
  assign mag      = diff_abs[ott_pkg::SENSOR_BITS-1:0];

  // 10*mag as 8*mag + 2*mag
  assign biased = ott_pkg::MAG_W'({mag, 3'b000}) + ott_pkg::MAG_W'({mag, 1'b0})
                + ott_pkg::MAG_W'(ott_pkg::ROUND_BIAS);

  assign scale_o.neg  = diff[ott_pkg::SENSOR_BITS];
  assign scale_o.prod = ott_pkg::PROD_W'(biased) * ott_pkg::PROD_W'(ott_pkg::RECIP);

endmodule

@@ hdl/ott_trim_map.sv @@
// ----------------------------------------------------------------------------
// ott_trim_map
// Signed temperature with saturation, table index clamp, delta lookup and
// trim sum clamp.
// ----------------------------------------------------------------------------
module ott_trim_map (
  input  logic                        neg_i,
  input  logic [ott_pkg::QUOT_W-1:0]  quot_i,
  input  logic [ott_pkg::BYTE_W-1:0]  cal_temp_i,
  input  logic [ott_pkg::BYTE_W-1:0]  default_trim_i,
  output ott_pkg::result_t            result_o
);

  localparam int TW = ott_pkg::TEMP_W;
  localparam int IW = ott_pkg::IDX_W;
  localparam int SW = ott_pkg::SUM_W;

  logic signed [TW-1:0] quot_s;
  logic signed [TW-1:0] temp_full;
  logic signed [ott_pkg::BYTE_W-1:0] temp;
  logic signed [IW-1:0] idx_full;
  logic idx_lo, idx_hi;
  logic [ott_pkg::BYTE_W-1:0] idx;
  logic signed [ott_pkg::DELTA_W-1:0] delta;
  logic signed [SW-1:0] sum;

  always_comb begin
    quot_s    = $signed({{(TW-ott_pkg::QUOT_W){1'b0}}, quot_i});
    temp_full = $signed({{(TW-ott_pkg::BYTE_W){1'b0}}, cal_temp_i})
              + (neg_i ? -quot_s : quot_s);

    if (temp_full > $signed(TW'(127))) begin
      temp = 8'sd127;
    end else if (temp_full < $signed(TW'(-128))) begin
      temp = -8'sd128;
    end else begin
      temp = temp_full[ott_pkg::BYTE_W-1:0];
    end

    idx_full = $signed({{(IW-ott_pkg::BYTE_W){temp[ott_pkg::BYTE_W-1]}}, temp})
             + $signed(IW'(ott_pkg::TEMP_BASE));
    idx_lo   = idx_full[IW-1];
    idx_hi   = idx_full > $signed(IW'(ott_pkg::TABLE_ENTRIES - 1));
    if (idx_lo) begin
      idx = '0;
    end else if (idx_hi) begin
      idx = ott_pkg::BYTE_W'(ott_pkg::TABLE_ENTRIES - 1);
    end else begin
      idx = idx_full[ott_pkg::BYTE_W-1:0];
    end

    delta = ott_pkg::trim_delta(idx);
    sum   = $signed({{(SW-ott_pkg::BYTE_W){1'b0}}, default_trim_i})
          + $signed({{(SW-ott_pkg::DELTA_W){delta[ott_pkg::DELTA_W-1]}}, delta});

    result_o.temp       = temp;
    result_o.idx_clamp  = idx_lo | idx_hi;
    result_o.trim_clamp = 1'b0;
    if (sum[SW-1]) begin
      result_o.trim       = '0;
      result_o.trim_clamp = 1'b1;
    end else if (sum > $signed(SW'(255))) begin
      result_o.trim       = 8'hff;
      result_o.trim_clamp = 1'b1;
    end else begin
      result_o.trim = sum[ott_pkg::BYTE_W-1:0];
    end
  end

endmodule

@@ hdl/oscillator_temp_trim_unit.sv @@
// ----------------------------------------------------------------------------
// oscillator_temp_trim_unit
// Converts a raw temperature sensor sample into degrees and an RC oscillator
// trim value from the factory default plus a per-degree delta.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive sensor_sample_i with start_i high; it is taken at any clock
//   edge where busy_o is low, and busy_o stays low, so one request per cycle.
//   Result: result_valid_o is high for one cycle with trim_value_o,
//   temperature_deg_o, index_clamped_o and trim_clamped_o. The receiver cannot
//   hold results off; results come out in request order.
//   Path: a request passes the input register, the product register and the
//   result register on its way to the ports. Throughput is one request per
//   cycle, set by the single registered multiply stage.
//   Configuration: cfg_we_i with cfg_addr_i writes cal temperature (0),
//   cal sensor code (1) or default trim (2) from the low bits of
//   cfg_wdata_i; other addresses are ignored. Write only while no request
//   is in flight.
//   Reset: clears the pipeline; cal temperature 25, cal code 0, trim 0.
// ----------------------------------------------------------------------------
module oscillator_temp_trim_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [ott_pkg::SAMPLE_W-1:0]     sensor_sample_i,
  input  logic                             cfg_we_i,
  input  logic [ott_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [ott_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                             result_valid_o,
  output logic [ott_pkg::BYTE_W-1:0]       trim_value_o,
  output logic signed [ott_pkg::BYTE_W-1:0] temperature_deg_o,
  output logic                             index_clamped_o,
  output logic                             trim_clamped_o
);

  logic [ott_pkg::BYTE_W-1:0]   cal_temp_q;
  logic [ott_pkg::SAMPLE_W-1:0] cal_code_q;
  logic [ott_pkg::BYTE_W-1:0]   default_trim_q;

  logic                         in_valid_q;
  logic [ott_pkg::SAMPLE_W-1:0] sample_q;
  logic                         scale_valid_q;
  ott_pkg::scale_t              scale_d, scale_q;
  logic                         res_valid_q;
  ott_pkg::result_t             result_d, result_q;
  logic                         accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q     <= ott_pkg::BYTE_W'(ott_pkg::CAL_TEMP_RESET);
      cal_code_q     <= '0;
      default_trim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ott_pkg::CFG_CAL_TEMPERATURE: cal_temp_q     <= cfg_wdata_i[ott_pkg::BYTE_W-1:0];
        ott_pkg::CFG_CAL_SENSOR_CODE: cal_code_q     <= cfg_wdata_i[ott_pkg::SAMPLE_W-1:0];
        ott_pkg::CFG_DEFAULT_TRIM:    default_trim_q <= cfg_wdata_i[ott_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      scale_valid_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      in_valid_q    <= accept;
      scale_valid_q <= in_valid_q;
      res_valid_q   <= scale_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sensor_sample_i;
    end
    if (in_valid_q) begin
      scale_q <= scale_d;
    end
    if (scale_valid_q) begin
      result_q <= result_d;
    end
  end

  ott_scale u_scale (
    .sample_i   (sample_q),
    .cal_code_i (cal_code_q),
    .scale_o    (scale_d)
  );

  ott_trim_map u_trim_map (
    .neg_i          (scale_q.neg),
    .quot_i         (scale_q.prod[ott_pkg::RECIP_SHIFT +: ott_pkg::QUOT_W]),
    .cal_temp_i     (cal_temp_q),
    .default_trim_i (default_trim_q),
    .result_o       (result_d)
  );

  assign result_valid_o    = res_valid_q;
  assign trim_value_o      = result_q.trim;
  assign temperature_deg_o = result_q.temp;
  assign index_clamped_o   = result_q.idx_clamp;
  assign trim_clamped_o    = result_q.trim_clamp;

endmodule

@@ hdl/ott_checker.sv @@
// ----------------------------------------------------------------------------
// ott_checker
// Port-level checks of the oscillator temperature trim unit, bound to the top.
// ----------------------------------------------------------------------------
module ott_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              result_valid_o,
  input logic [ott_pkg::BYTE_W-1:0]        trim_value_o,
  input logic signed [ott_pkg::BYTE_W-1:0] temperature_deg_o,
  input logic                              index_clamped_o,
  input logic                              trim_clamped_o
);

  localparam int TEMP_LO = -ott_pkg::TEMP_BASE;
  localparam int TEMP_HI = ott_pkg::TABLE_ENTRIES - 1 - ott_pkg::TEMP_BASE;

  // every request gives exactly one result
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 result_valid_o)
    else $error("request without result");

  a_result_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 3))
    else $error("result without request");

  // index clamp flag matches the reported temperature
  a_idx_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> index_clamped_o ==
      (int'(temperature_deg_o) < TEMP_LO || int'(temperature_deg_o) > TEMP_HI))
    else $error("index clamp flag disagrees with temperature");

  // a clamped trim sits on a rail
  a_trim_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && trim_clamped_o |-> trim_value_o == 8'h00 || trim_value_o == 8'hff)
    else $error("clamped trim off rail");

endmodule

bind oscillator_temp_trim_unit ott_checker u_ott_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .result_valid_o    (result_valid_o),
  .trim_value_o      (trim_value_o),
  .temperature_deg_o (temperature_deg_o),
  .index_clamped_o   (index_clamped_o),
  .trim_clamped_o    (trim_clamped_o)
);
